FILE: design/speed_pid_throttle_assert.svh
// Assertion macros for the speed PID throttle block.
// Used by speed_pid_throttle.sv; needs clk and arst_n in scope.
`ifndef SPEED_PID_THROTTLE_ASSERT_SVH
`define SPEED_PID_THROTTLE_ASSERT_SVH
// Implication checked at every rising edge outside reset.
`define SPT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define SPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/spt_pkg.sv
// Shared types and constants for the speed PID throttle block.
// No dependencies.
package spt_pkg;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned OUT_W = 23;
	localparam int unsigned ERR_W = 34;
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_PROP = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_TIME = 2'd3;
	localparam logic [DATA_W-1:0] STEP_TIME_RESET = 32'd6554;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,    // take the beat, start the root
		OP_ROOT,    // one root step
		OP_ERR,     // form error, load integral product
		OP_MUL,     // one multiplier partial product
		OP_ACC,     // add the integral term and saturate
		OP_DIVSTART,// start both divisions
		OP_DIV,     // one step of both dividers
		OP_CLAMP,   // apply integral clamp, form derivative
		OP_TERM,    // load a gain term into the multiplier
		OP_SUM,     // add multiplier result into the sum
		OP_OUT      // clamp sum into the output register
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel;  // which term for OP_TERM (unused by OP_SUM)
	} cmd_t;

	typedef struct packed {
		logic root_done;
		logic mul_done;
		logic div_done;
	} stat_t;
endpackage

FILE: design/spt_datapath.sv
// Datapath of the speed PID throttle: root, shared multiplier, dividers.
// Depends on spt_pkg; driven by spt_ctrl.
module spt_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spt_pkg::cmd_t               cmd,
	output spt_pkg::stat_t              stat,
	input  logic signed [spt_pkg::DATA_W-1:0] vel_north,
	input  logic signed [spt_pkg::DATA_W-1:0] vel_east,
	input  logic signed [spt_pkg::DATA_W-1:0] target_speed,
	input  logic [spt_pkg::DATA_W-1:0]  gain_prop_q,
	input  logic [spt_pkg::DATA_W-1:0]  gain_integ_q,
	input  logic [spt_pkg::DATA_W-1:0]  gain_deriv_q,
	input  logic [spt_pkg::DATA_W-1:0]  step_time_q,
	output logic [spt_pkg::OUT_W-1:0]   throttle_q
);
	localparam int DW = spt_pkg::DATA_W;
	localparam int EW = spt_pkg::ERR_W;
	localparam int OUT_W = spt_pkg::OUT_W;
	localparam logic [63:0] TERM_MAX = 64'h1FFF_FFFF_FFFF_FFFF;
	localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam int DIVD_W = 64;                 // diff magnitude << F fits
	localparam int DIV_STEPS = 64;
	localparam int DCNT_W = 7;
	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);
	localparam logic [68:0] OUT_MAX = 69'(100) << FRAC_BITS;

	// root
	logic [63:0] rx_q, rres_q, rbit_q;
	// error and state
	logic signed [EW-1:0] err_q, last_err_q;
	logic signed [ACC_WIDTH-1:0] acc_q;
	// multiplier: magnitude a (64b) times b (32b) in two 32x32 partial products
	logic [63:0] ma_q;
	logic [31:0] mb_q;
	logic        mneg_q, mphase_q, mbusy_q;
	logic [95:0] mprod_q;
	logic signed [63:0] mres_q;
	// dividers
	logic [DCNT_W-1:0] dcnt_q;
	logic        dbusy_q;
	logic [DIVD_W-1:0] lrem_q, lquo_q;
	logic [DIVD_W-1:0] drem_q, dquo_q, dnum_q;
	logic        dneg_q;
	logic signed [63:0] deriv_q;
	logic signed [68:0] sum_q;

	logic [63:0] sq_n, sq_e, rtry;
	logic [63:0] shifted, mmag;
	logic [31:0] dt;
	logic signed [EW-1:0] err_new;
	logic signed [EW:0] diff;
	logic [DIVD_W:0] lrem_sh, drem_sh;
	logic [DIVD_W-1:0] lnum;
	logic signed [ACC_WIDTH+1:0] acc_sum;
	logic signed [ACC_WIDTH:0] lim;
	logic [31:0] mag_n, mag_e;

	assign dt = (step_time_q == '0) ? 32'd1 : step_time_q;
	assign mag_n = vel_north[DW-1] ? 32'(-vel_north) : 32'(vel_north);
	assign mag_e = vel_east[DW-1] ? 32'(-vel_east) : 32'(vel_east);
	assign sq_n = 64'(mag_n) * 64'(mag_n);
	assign sq_e = 64'(mag_e) * 64'(mag_e);
	assign rtry = rres_q + rbit_q;
	assign err_new = EW'(target_speed) - $signed(EW'(rres_q));
	assign diff = (EW+1)'(err_q) - (EW+1)'(last_err_q);
	assign lnum = DIVD_W'(50) << (2 * FRAC_BITS);
	assign lrem_sh = {lrem_q, lquo_q[DIVD_W-1]};
	assign drem_sh = {drem_q, dnum_q[DIVD_W-1]};
	assign acc_sum = (ACC_WIDTH+2)'(acc_q) + (ACC_WIDTH+2)'(mres_q);

	// Saturated, truncated result of the 96-bit product.
	always_comb begin
		shifted = 64'(mprod_q >> FRAC_BITS);
		if ((mprod_q >> (64 + FRAC_BITS)) != '0 || shifted > TERM_MAX) mmag = TERM_MAX;
		else mmag = shifted;
	end

	// Limit from the quotient, capped at the accumulator maximum.
	always_comb begin
		if (lquo_q > 64'(AMAX)) lim = (ACC_WIDTH+1)'(AMAX);
		else lim = (ACC_WIDTH+1)'(lquo_q);
	end

	assign stat.root_done = (rbit_q == '0);
	assign stat.mul_done = !mbusy_q;
	assign stat.div_done = !dbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			last_err_q <= '0;
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
			rbit_q <= '0;
			throttle_q <= '0;
		end else begin
			case (cmd.op)
				spt_pkg::OP_LOAD: begin
					rx_q <= sq_n + sq_e;
					rres_q <= '0;
					rbit_q <= 64'(1) << 62;
				end
				spt_pkg::OP_ROOT: begin
					if (rbit_q > rx_q && rres_q == '0) begin
						rbit_q <= rbit_q >> 2;
					end else if (rx_q >= rtry) begin
						rx_q <= rx_q - rtry;
						rres_q <= (rres_q >> 1) + rbit_q;
						rbit_q <= rbit_q >> 2;
					end else begin
						rres_q <= rres_q >> 1;
						rbit_q <= rbit_q >> 2;
					end
				end
				spt_pkg::OP_ERR: begin
					err_q <= err_new;
					ma_q <= err_new < 0 ? 64'(-err_new) : 64'(err_new);
					mneg_q <= err_new < 0;
					mb_q <= dt;
					mprod_q <= '0;
					mphase_q <= 1'b0;
					mbusy_q <= 1'b1;
				end
				spt_pkg::OP_MUL: begin
					if (!mphase_q) begin
						mprod_q <= 96'(64'(ma_q[31:0]) * 64'(mb_q));
						mphase_q <= 1'b1;
					end else begin
						mprod_q <= mprod_q + (96'(64'(ma_q[63:32]) * 64'(mb_q)) << 32);
						mbusy_q <= 1'b0;
					end
				end
				spt_pkg::OP_ACC: begin
					if (acc_sum > (ACC_WIDTH+2)'(AMAX)) acc_q <= AMAX;
					else if (acc_sum < (ACC_WIDTH+2)'(AMIN)) acc_q <= AMIN;
					else acc_q <= ACC_WIDTH'(acc_sum);
				end
				spt_pkg::OP_DIVSTART: begin
					lrem_q <= '0;
					lquo_q <= lnum;
					drem_q <= '0;
					dquo_q <= '0;
					dnum_q <= 64'(diff < 0 ? -diff : diff) << FRAC_BITS;
					dneg_q <= diff < 0;
					dcnt_q <= '0;
					dbusy_q <= 1'b1;
				end
				spt_pkg::OP_DIV: begin
					// Restoring division, one bit of each quotient per cycle.
					if (lrem_sh >= (DIVD_W+1)'(gain_integ_q)) begin
						lrem_q <= DIVD_W'(lrem_sh - (DIVD_W+1)'(gain_integ_q));
						lquo_q <= {lquo_q[DIVD_W-2:0], 1'b1};
					end else begin
						lrem_q <= DIVD_W'(lrem_sh);
						lquo_q <= {lquo_q[DIVD_W-2:0], 1'b0};
					end
					if (drem_sh >= (DIVD_W+1)'(dt)) begin
						drem_q <= DIVD_W'(drem_sh - (DIVD_W+1)'(dt));
						dquo_q <= {dquo_q[DIVD_W-2:0], 1'b1};
					end else begin
						drem_q <= DIVD_W'(drem_sh);
						dquo_q <= {dquo_q[DIVD_W-2:0], 1'b0};
					end
					dnum_q <= dnum_q << 1;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DIV_LAST) dbusy_q <= 1'b0;
				end
				spt_pkg::OP_CLAMP: begin
					if (gain_integ_q != '0) begin
						if ((ACC_WIDTH+1)'(acc_q) > lim) acc_q <= ACC_WIDTH'(lim);
						else if ((ACC_WIDTH+1)'(acc_q) < -lim) acc_q <= ACC_WIDTH'(-lim);
					end
					deriv_q <= dneg_q ? -$signed(dquo_q) : $signed(dquo_q);
					last_err_q <= err_q;
					sum_q <= '0;
				end
				spt_pkg::OP_TERM: begin
					case (cmd.sel)
						2'd0: begin
							ma_q <= err_q < 0 ? 64'(-err_q) : 64'(err_q);
							mneg_q <= err_q < 0;
							mb_q <= gain_prop_q;
						end
						2'd1: begin
							// Widen before negating so the most negative value keeps its size.
							ma_q <= acc_q < 0 ? -64'(acc_q) : 64'(acc_q);
							mneg_q <= acc_q < 0;
							mb_q <= gain_integ_q;
						end
						default: begin
							ma_q <= deriv_q < 0 ? 64'(-deriv_q) : 64'(deriv_q);
							mneg_q <= deriv_q < 0;
							mb_q <= gain_deriv_q;
						end
					endcase
					mphase_q <= 1'b0;
					mbusy_q <= 1'b1;
				end
				spt_pkg::OP_SUM: begin
					sum_q <= sum_q + 69'(mres_q);
				end
				spt_pkg::OP_OUT: begin
					if (sum_q < 0) throttle_q <= '0;
					else if (sum_q > $signed(OUT_MAX)) throttle_q <= OUT_W'(OUT_MAX);
					else throttle_q <= OUT_W'(sum_q);
				end
				default: ;
			endcase
		end
	end

	// Signed multiplier result, registered apart from the product.
	always_ff @(posedge clk) begin
		mres_q <= mneg_q ? -$signed(mmag) : $signed(mmag);
	end
endmodule

FILE: design/spt_ctrl.sv
// Sequencer of the speed PID throttle: handshakes and datapath commands.
// Depends on spt_pkg; drives spt_datapath.
module spt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  spt_pkg::stat_t stat,
	output spt_pkg::cmd_t  cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_ROOT, S_ERR, S_MUL, S_WAITR, S_ACC, S_DIVS, S_DIV,
		S_CLAMP, S_TERM, S_TMUL, S_TWAIT, S_TSUM, S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] term_q;

	assign in_ready = (state_q == S_IDLE) && !(out_valid && !out_ready);

	// Iterative steps are issued only while their unit still reports work to do.
	always_comb begin
		cmd.op = spt_pkg::OP_NONE;
		cmd.sel = term_q;
		case (state_q)
			S_IDLE:  if (in_valid && in_ready) cmd.op = spt_pkg::OP_LOAD;
			S_ROOT:  if (!stat.root_done) cmd.op = spt_pkg::OP_ROOT;
			S_ERR:   cmd.op = spt_pkg::OP_ERR;
			S_MUL:   if (!stat.mul_done) cmd.op = spt_pkg::OP_MUL;
			S_TMUL:  if (!stat.mul_done) cmd.op = spt_pkg::OP_MUL;
			S_ACC:   cmd.op = spt_pkg::OP_ACC;
			S_DIVS:  cmd.op = spt_pkg::OP_DIVSTART;
			S_DIV:   if (!stat.div_done) cmd.op = spt_pkg::OP_DIV;
			S_CLAMP: cmd.op = spt_pkg::OP_CLAMP;
			S_TERM:  cmd.op = spt_pkg::OP_TERM;
			S_TSUM:  cmd.op = spt_pkg::OP_SUM;
			S_OUT:   cmd.op = spt_pkg::OP_OUT;
			default: cmd.op = spt_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			term_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_ROOT;
				end
				S_ROOT:  if (stat.root_done) state_q <= S_ERR;
				S_ERR:   state_q <= S_MUL;
				S_MUL:   if (stat.mul_done) state_q <= S_WAITR;
				S_WAITR: state_q <= S_ACC;
				S_ACC:   state_q <= S_DIVS;
				S_DIVS:  state_q <= S_DIV;
				S_DIV:   if (stat.div_done) state_q <= S_CLAMP;
				S_CLAMP: begin
					term_q <= '0;
					state_q <= S_TERM;
				end
				S_TERM:  state_q <= S_TMUL;
				S_TMUL:  if (stat.mul_done) state_q <= S_TWAIT;
				S_TWAIT: state_q <= S_TSUM;
				S_TSUM: begin
					if (term_q == 2'd2) state_q <= S_OUT;
					else begin
						term_q <= term_q + 2'd1;
						state_q <= S_TERM;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: design/speed_pid_throttle.sv
// Top level of the speed PID throttle controller with anti-windup.
// Depends on spt_pkg, spt_ctrl, spt_datapath and speed_pid_throttle_assert.svh.
//
//  channel   signals                                      direction
//  input     in_valid/in_ready, vel_north, vel_east,       in
//            target_speed
//  result    out_valid/out_ready, throttle                out
//  config    cfg_we, cfg_index, cfg_data                  in
//
// The result beat is offered once an item has run through the root (32 steps
// and a final check), the two restoring dividers run side by side (64 steps),
// four passes of the shared 32x32 multiplier and the single steps between. No
// new input beat is taken before the last one is through, and the next one can
// be taken in the same cycle the result is offered if out_ready is high. Reset
// clears the accumulator, last error and gains and loads the default step time.
// The input is held off while an item is at work or a result still waits.
`include "speed_pid_throttle_assert.svh"
module speed_pid_throttle #(
	parameter int FRAC_BITS = 16,
	parameter int ACC_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [spt_pkg::DATA_W-1:0] vel_north,
	input  logic signed [spt_pkg::DATA_W-1:0] vel_east,
	input  logic signed [spt_pkg::DATA_W-1:0] target_speed,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [spt_pkg::OUT_W-1:0]         throttle,
	input  logic                              cfg_we,
	input  logic [spt_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [spt_pkg::DATA_W-1:0]        cfg_data
);
	spt_pkg::cmd_t  cmd;
	spt_pkg::stat_t stat;
	logic [spt_pkg::DATA_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q, step_time_q;
	logic signed [spt_pkg::DATA_W-1:0] vn_q, ve_q, tgt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			step_time_q <= spt_pkg::STEP_TIME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				spt_pkg::REG_GAIN_PROP:  gain_prop_q <= cfg_data;
				spt_pkg::REG_GAIN_INTEG: gain_integ_q <= cfg_data;
				spt_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg_data;
				spt_pkg::REG_STEP_TIME:  step_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input beat is captured so the datapath may read it for many cycles.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vn_q <= vel_north;
			ve_q <= vel_east;
			tgt_q <= target_speed;
		end
	end

	spt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	spt_datapath #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.vel_north(in_valid && in_ready ? vel_north : vn_q),
		.vel_east(in_valid && in_ready ? vel_east : ve_q),
		.target_speed(tgt_q),
		.gain_prop_q(gain_prop_q), .gain_integ_q(gain_integ_q),
		.gain_deriv_q(gain_deriv_q), .step_time_q(step_time_q),
		.throttle_q(throttle)
	);

	`SPT_ASSERT_IMP(a_thr_range, out_valid, throttle <= (23'd100 << FRAC_BITS), "throttle out of range")
	`SPT_ASSERT_IMP(a_no_take_busy, out_valid && !out_ready, !in_ready, "input taken while result waits")
	`SPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(throttle), "result dropped")
endmodule
